@@ design/tacho_wheel_speed_estimator_assert.svh @@
// Assertion macros used by the tachometer speed estimator checker
`ifndef TACHO_WHEEL_SPEED_ESTIMATOR_ASSERT_SVH
`define TACHO_WHEEL_SPEED_ESTIMATOR_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define TWS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tacho speed estimator check failed");

// Check a consequence in the cycle after its trigger
`define TWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tacho speed estimator check failed");

`endif

@@ design/tws_pkg.sv @@
// Shared types and constants of the tachometer speed estimator
package tws_pkg;

    // Input word operations
    localparam logic [1:0] OP_EDGE     = 2'd0;
    localparam logic [1:0] OP_OVERFLOW = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPEED_SCALE    = 3'd0;
    localparam logic [2:0] CFG_MAX_RATIO_FAST = 3'd1;
    localparam logic [2:0] CFG_MIN_RATIO_FAST = 3'd2;
    localparam logic [2:0] CFG_MAX_RATIO_SLOW = 3'd3;
    localparam logic [2:0] CFG_MIN_RATIO_SLOW = 3'd4;
    localparam logic [2:0] CFG_SLOW_LIMIT     = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT        = 3'd6;

    // Configuration reset values
    localparam logic [31:0] RST_SPEED_SCALE    = 32'd7680000;
    localparam logic [15:0] RST_MAX_RATIO_FAST = 16'd512;
    localparam logic [15:0] RST_MIN_RATIO_FAST = 16'd128;
    localparam logic [15:0] RST_MAX_RATIO_SLOW = 16'd1024;
    localparam logic [15:0] RST_MIN_RATIO_SLOW = 16'd64;
    localparam logic [15:0] RST_SLOW_LIMIT     = 16'd256;
    localparam logic [15:0] RST_TIMEOUT        = 16'd40;

    // Filter weights: new = (7*old + 3*sample) / 10
    localparam logic [27:0] EMA_KEEP = 28'd7;
    localparam logic [27:0] EMA_NEW  = 28'd3;
    localparam logic [27:0] EMA_DIV  = 28'd10;

    // Published speed must reach 0.01 m/s to add distance
    localparam logic [15:0] MIN_DIST_SPEED = 16'd3;
    localparam logic [23:0] MAX_SPEED24    = 24'hFF_FFFF;
    localparam logic [15:0] MAX_U16        = 16'hFFFF;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/tws_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module tws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/tws_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle
module tws_div
    import tws_pkg::*;
#(
    parameter int W = 35
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output div_stat_t    stat
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     den_reg;

    logic [W:0]       rem_shift;
    logic [W:0]       rem_diff;

    // Shift in the next numerator bit and trial-subtract
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (!rem_diff[W])
                begin
                    rem_reg <= rem_diff[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ design/tacho_wheel_speed_estimator.sv @@
// Tachometer wheel speed estimator: top level sequencer and state
// Overflow, tick and clear words and zero periods go from S_IDLE straight to S_FINISH.
// Other edges: serial ratio products in S_MUL and S_CMP when the check applies (ending there if rejected),
// then S_WRITE, a read and an add per summed ring entry, two divider passes (rate, then filter)
// and S_FINISH for the hand-off to the output register; the bit-serial divider does the division.
// One word is in work at a time; a finished word waits until the output register is free.
// Reset (rst_n, async, low) clears all state and loads the register defaults.
module tacho_wheel_speed_estimator
    import tws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] capture_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] speed_now,
    output logic [47:0] distance,
    output logic        period_accepted,
    output logic        timed_out
);

    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int DIV_W  = 32 + FILL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_WRITE,
        S_SUM_RD,
        S_SUM_ACC,
        S_RATE_GO,
        S_RATE_WAIT,
        S_EMA_GO,
        S_EMA_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [31:0] speed_scale_reg;
    logic [15:0] max_fast_reg;
    logic [15:0] min_fast_reg;
    logic [15:0] max_slow_reg;
    logic [15:0] min_slow_reg;
    logic [15:0] slow_limit_reg;
    logic [15:0] timeout_reg;

    // Estimator state
    logic [15:0]       ovf_cnt_reg;
    logic [31:0]       last_ts_reg;
    logic [POS_W-1:0]  ring_pos_reg;
    logic [FILL_W-1:0] ring_fill_reg;
    logic [31:0]       last_valid_reg;
    logic [23:0]       filtered_reg;
    logic [15:0]       published_reg;
    logic              pending_reg;
    logic [47:0]       dist_reg;
    logic [15:0]       ticks_reg;

    // Edge work registers
    logic [31:0]       per_reg;
    logic [15:0]       hi_lim_reg;
    logic [15:0]       lo_lim_reg;
    logic [47:0]       mcand_reg;
    logic [47:0]       acc_hi_reg;
    logic [47:0]       acc_lo_reg;
    logic [3:0]        mul_cnt_reg;
    logic [FILL_W-1:0] rd_cnt_reg;
    logic [DIV_W-1:0]  sum_reg;
    logic [23:0]       sp_reg;

    // Result staging and output registers
    logic [15:0] res_speed_reg;
    logic [47:0] res_dist_reg;
    logic        res_acc_reg;
    logic        res_tmo_reg;
    logic        out_valid_reg;
    logic [15:0] out_speed_reg;
    logic [47:0] out_dist_reg;
    logic        out_acc_reg;
    logic        out_tmo_reg;

    // Combinational helpers
    logic              in_fire;
    logic [31:0]       stamp;
    logic [31:0]       per;
    logic              use_slow;
    logic              ratio_check;
    logic [15:0]       ticks_inc;
    logic              tmo;
    logic [23:0]       filt_after;
    logic [15:0]       pub_after;
    logic [47:0]       dist_tick;
    logic [47:0]       scaled;
    logic              out_free;
    logic [DIV_W-1:0]  rate_num;
    logic [27:0]       ema_num;
    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic [DIV_W-1:0]  div_den;
    logic [DIV_W-1:0]  div_quo;
    div_stat_t         div_stat;
    logic [31:0]       ram_rdata;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Extend the capture and take the period
    assign stamp       = {ovf_cnt_reg, capture_value};
    assign per         = stamp - last_ts_reg;
    assign use_slow    = (filtered_reg < {8'd0, slow_limit_reg});
    assign ratio_check = (last_valid_reg != 32'd0) && (filtered_reg != 24'd0);
    assign scaled      = {8'd0, per_reg, 8'd0};

    // Tick: integrate, time out, publish
    assign ticks_inc  = (ticks_reg != MAX_U16) ? ticks_reg + 16'd1 : ticks_reg;
    assign tmo        = (ticks_inc > timeout_reg);
    assign dist_tick  = (published_reg >= MIN_DIST_SPEED) ?
                        dist_reg + {32'd0, published_reg} : dist_reg;
    assign filt_after = tmo ? 24'd0 : filtered_reg;
    always_comb
    begin
        if (pending_reg)
        begin
            pub_after = (|filt_after[23:16]) ? MAX_U16 : filt_after[15:0];
        end
        else if (tmo)
        begin
            pub_after = 16'd0;
        end
        else
        begin
            pub_after = published_reg;
        end
    end

    // Divider operands: rate first, then the filter update
    assign rate_num  = DIV_W'(speed_scale_reg) * DIV_W'(ring_fill_reg);
    assign ema_num   = 28'(filtered_reg) * EMA_KEEP + 28'(sp_reg) * EMA_NEW;
    assign div_start = (state_reg == S_RATE_GO) || (state_reg == S_EMA_GO);
    assign div_num   = (state_reg == S_RATE_GO) ? rate_num : DIV_W'(ema_num);
    assign div_den   = (state_reg == S_RATE_GO) ? sum_reg : DIV_W'(EMA_DIV);

    tws_div #(
        .W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    tws_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_WRITE),
        .waddr (ring_pos_reg),
        .wdata (per_reg),
        .raddr (rd_cnt_reg[POS_W-1:0]),
        .rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg <= RST_SPEED_SCALE;
            max_fast_reg    <= RST_MAX_RATIO_FAST;
            min_fast_reg    <= RST_MIN_RATIO_FAST;
            max_slow_reg    <= RST_MAX_RATIO_SLOW;
            min_slow_reg    <= RST_MIN_RATIO_SLOW;
            slow_limit_reg  <= RST_SLOW_LIMIT;
            timeout_reg     <= RST_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED_SCALE:    speed_scale_reg <= cfg_data;
                CFG_MAX_RATIO_FAST: max_fast_reg    <= cfg_data[15:0];
                CFG_MIN_RATIO_FAST: min_fast_reg    <= cfg_data[15:0];
                CFG_MAX_RATIO_SLOW: max_slow_reg    <= cfg_data[15:0];
                CFG_MIN_RATIO_SLOW: min_slow_reg    <= cfg_data[15:0];
                CFG_SLOW_LIMIT:     slow_limit_reg  <= cfg_data[15:0];
                CFG_TIMEOUT:        timeout_reg     <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // Sequencer, estimator state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ovf_cnt_reg    <= '0;
            last_ts_reg    <= '0;
            ring_pos_reg   <= '0;
            ring_fill_reg  <= '0;
            last_valid_reg <= '0;
            filtered_reg   <= '0;
            published_reg  <= '0;
            pending_reg    <= 1'b0;
            dist_reg       <= '0;
            ticks_reg      <= '0;
            per_reg        <= '0;
            hi_lim_reg     <= '0;
            lo_lim_reg     <= '0;
            mcand_reg      <= '0;
            acc_hi_reg     <= '0;
            acc_lo_reg     <= '0;
            mul_cnt_reg    <= '0;
            rd_cnt_reg     <= '0;
            sum_reg        <= '0;
            sp_reg         <= '0;
            res_speed_reg  <= '0;
            res_dist_reg   <= '0;
            res_acc_reg    <= 1'b0;
            res_tmo_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_speed_reg  <= '0;
            out_dist_reg   <= '0;
            out_acc_reg    <= 1'b0;
            out_tmo_reg    <= 1'b0;
        end
        else
        begin
            // Drop the output word once taken
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_acc_reg <= 1'b0;
                        res_tmo_reg <= 1'b0;
                        state_reg   <= S_FINISH;
                        case (op)
                            OP_EDGE:
                            begin
                                last_ts_reg   <= stamp;
                                ticks_reg     <= '0;
                                pending_reg   <= 1'b1;
                                per_reg       <= per;
                                res_speed_reg <= published_reg;
                                res_dist_reg  <= dist_reg;
                                hi_lim_reg    <= use_slow ? max_slow_reg : max_fast_reg;
                                lo_lim_reg    <= use_slow ? min_slow_reg : min_fast_reg;
                                mcand_reg     <= {16'd0, last_valid_reg};
                                acc_hi_reg    <= '0;
                                acc_lo_reg    <= '0;
                                mul_cnt_reg   <= '0;
                                if (per == 32'd0)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else if (ratio_check)
                                begin
                                    state_reg <= S_MUL;
                                end
                                else
                                begin
                                    state_reg <= S_WRITE;
                                end
                            end
                            OP_OVERFLOW:
                            begin
                                ovf_cnt_reg   <= ovf_cnt_reg + 16'd1;
                                res_speed_reg <= published_reg;
                                res_dist_reg  <= dist_reg;
                            end
                            OP_TICK:
                            begin
                                dist_reg      <= dist_tick;
                                ticks_reg     <= ticks_inc;
                                pending_reg   <= 1'b0;
                                published_reg <= pub_after;
                                filtered_reg  <= filt_after;
                                if (tmo)
                                begin
                                    ring_fill_reg  <= '0;
                                    ring_pos_reg   <= '0;
                                    last_valid_reg <= '0;
                                end
                                res_speed_reg <= pub_after;
                                res_dist_reg  <= dist_tick;
                                res_tmo_reg   <= tmo;
                            end
                            OP_CLEAR:
                            begin
                                dist_reg      <= '0;
                                res_speed_reg <= published_reg;
                                res_dist_reg  <= dist_reg;
                            end
                            default:
                            begin
                                res_speed_reg <= published_reg;
                                res_dist_reg  <= dist_reg;
                            end
                        endcase
                    end
                end

                // Form limit*last_valid one limit bit a cycle
                S_MUL:
                begin
                    if (hi_lim_reg[0])
                    begin
                        acc_hi_reg <= acc_hi_reg + mcand_reg;
                    end
                    if (lo_lim_reg[0])
                    begin
                        acc_lo_reg <= acc_lo_reg + mcand_reg;
                    end
                    hi_lim_reg  <= {1'b0, hi_lim_reg[15:1]};
                    lo_lim_reg  <= {1'b0, lo_lim_reg[15:1]};
                    mcand_reg   <= {mcand_reg[46:0], 1'b0};
                    mul_cnt_reg <= mul_cnt_reg + 4'd1;
                    if (mul_cnt_reg == 4'd15)
                    begin
                        state_reg <= S_CMP;
                    end
                end

                // Reject ratio outliers
                S_CMP:
                begin
                    if ((scaled > acc_hi_reg) || (scaled < acc_lo_reg))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end

                // Store the period in the ring
                S_WRITE:
                begin
                    last_valid_reg <= per_reg;
                    ring_pos_reg   <= (ring_pos_reg == POS_W'(WINDOW_DEPTH - 1)) ?
                                      '0 : ring_pos_reg + 1'b1;
                    if (ring_fill_reg < FILL_W'(WINDOW_DEPTH))
                    begin
                        ring_fill_reg <= ring_fill_reg + 1'b1;
                    end
                    rd_cnt_reg <= '0;
                    sum_reg    <= '0;
                    state_reg  <= S_SUM_RD;
                end

                // Sum the filled entries, one read per entry
                S_SUM_RD:
                begin
                    state_reg <= S_SUM_ACC;
                end

                S_SUM_ACC:
                begin
                    sum_reg    <= sum_reg + DIV_W'(ram_rdata);
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (FILL_W'(rd_cnt_reg + 1'b1) == ring_fill_reg)
                    begin
                        state_reg <= S_RATE_GO;
                    end
                    else
                    begin
                        state_reg <= S_SUM_RD;
                    end
                end

                S_RATE_GO:
                begin
                    state_reg <= S_RATE_WAIT;
                end

                // Saturate the raw speed
                S_RATE_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        if (sum_reg == '0)
                        begin
                            sp_reg <= '0;
                        end
                        else if (|div_quo[DIV_W-1:24])
                        begin
                            sp_reg <= MAX_SPEED24;
                        end
                        else
                        begin
                            sp_reg <= div_quo[23:0];
                        end
                        state_reg <= S_EMA_GO;
                    end
                end

                S_EMA_GO:
                begin
                    state_reg <= S_EMA_WAIT;
                end

                // Update the smoothed speed
                S_EMA_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        filtered_reg <= div_quo[23:0];
                        res_acc_reg  <= 1'b1;
                        state_reg    <= S_FINISH;
                    end
                end

                // Hand the word to the output register
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_speed_reg <= res_speed_reg;
                        out_dist_reg  <= res_dist_reg;
                        out_acc_reg   <= res_acc_reg;
                        out_tmo_reg   <= res_tmo_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign speed_now       = out_speed_reg;
    assign distance        = out_dist_reg;
    assign period_accepted = out_acc_reg;
    assign timed_out       = out_tmo_reg;

endmodule

@@ design/tws_checker.sv @@
// Port-level checker for the tachometer speed estimator, bound to the top level
`include "tacho_wheel_speed_estimator_assert.svh"

module tws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] speed_now,
    input logic [47:0] distance,
    input logic        period_accepted,
    input logic        timed_out
);

    // Hold a stalled output word
    `TWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(speed_now) && $stable(distance))

    // One word in work at a time
    `TWS_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready)

    // A word is never both an accepted edge and a timeout tick
    `TWS_ASSERT_NOW(a_acc_tmo_excl, out_valid, !(period_accepted && timed_out))

    // A timeout leaves the published speed at zero
    `TWS_ASSERT_NOW(a_tmo_zero_speed, out_valid && timed_out, speed_now == 16'd0)

endmodule

bind tacho_wheel_speed_estimator tws_checker u_tws_checker (.*);

@@ tb/tacho_wheel_speed_estimator_tb.sv @@
// Self-checking testbench for the tachometer wheel speed estimator
module tacho_wheel_speed_estimator_tb;
    import tws_pkg::*;

    localparam int WINDOW       = 6;
    localparam int DIR_ROWS     = 22;
    localparam int PHASES       = 6;
    localparam int PER_PHASE    = 190;
    localparam int TOTAL_WORDS  = DIR_ROWS + PHASES * PER_PHASE;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 3000;
    localparam int END_WAIT     = 200;
    localparam int LIMIT_CYCLES = 1000000;

    // One result word as the block presents it
    typedef struct packed {
        logic [15:0] speed;
        logic [47:0] travel;
        logic        acc;
        logic        tmo;
    } speed_word_t;

    // One row of the directed table; typed rows carry their own result
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cap;
        logic        typed;
        logic [15:0] speed;
        logic [47:0] travel;
        logic        acc;
        logic        tmo;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [15:0] capture_value;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] speed_now;
    logic [47:0] distance;
    logic        period_accepted;
    logic        timed_out;

    // Settings mirror
    logic [31:0] set_scale;
    logic [15:0] set_max_fast;
    logic [15:0] set_min_fast;
    logic [15:0] set_max_slow;
    logic [15:0] set_min_slow;
    logic [15:0] set_slow_lim;
    logic [15:0] set_timeout;
    logic [31:0] next_cfg [8];

    // Estimator state mirror
    logic [15:0] est_ovf;
    logic [31:0] est_last_stamp;
    logic [31:0] est_ring [WINDOW];
    logic [2:0]  est_pos;
    logic [2:0]  est_fill;
    logic [31:0] est_last_per;
    logic [23:0] est_filt;
    logic [15:0] est_pub;
    logic        est_pending;
    logic [47:0] est_dist;
    logic [15:0] est_ticks;

    speed_word_t speed_words_due [$];
    speed_word_t want;
    int          items_in = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_done = 1'b0;
    int          fails = 0;
    int          n_words = 0;
    int          n_taken = 0;
    int          n_timeouts = 0;
    int          n_saturated = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_TICK,     16'h0000, 1'b1, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_TICK,     16'hFFFF, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_TICK,     16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_TICK,     16'h0000, 1'b1, 16'd0, 48'd0, 1'b0, 1'b1},
        '{OP_TICK,     16'h0000, 1'b1, 16'd0, 48'd0, 1'b0, 1'b1},
        '{OP_CLEAR,    16'hFFFF, 1'b1, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'h0000, 1'b1, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'hFFFF, 1'b1, 16'd0, 48'd0, 1'b1, 1'b0},
        '{OP_TICK,     16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_TICK,     16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_OVERFLOW, 16'hFFFF, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'h8000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'hFFFF, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_OVERFLOW, 16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_OVERFLOW, 16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'hAAAA, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'h5555, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_TICK,     16'h5555, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_CLEAR,    16'hAAAA, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_TICK,     16'h0000, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0},
        '{OP_EDGE,     16'hFFFF, 1'b0, 16'd0, 48'd0, 1'b0, 1'b0}
    };

    tacho_wheel_speed_estimator #(
        .WINDOW_DEPTH(WINDOW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .capture_value(capture_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .speed_now(speed_now),
        .distance(distance),
        .period_accepted(period_accepted),
        .timed_out(timed_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // 16-bit register value with junk in the unused upper half
    function automatic logic [31:0] reg16(input logic [15:0] v);
        return {16'($urandom), v};
    endfunction

    // Advance the state mirror by one input word and form its result word
    task automatic predict_speed_word(input logic [1:0] w_op, input logic [15:0] w_cap,
                                      output speed_word_t r);
        logic [31:0] stamp;
        logic [31:0] per;
        logic [63:0] scaled;
        logic [63:0] hi_lim;
        logic [63:0] lo_lim;
        logic [63:0] sum;
        logic [63:0] spd;
        logic [63:0] filt_next;
        bit          take;
        r = '0;
        r.travel = est_dist;
        case (w_op)
            OP_EDGE:
            begin
                stamp = {est_ovf, w_cap};
                per = stamp - est_last_stamp;
                est_last_stamp = stamp;
                est_ticks = 16'd0;
                take = (per != 32'd0);
                hi_lim = 64'(set_max_fast);
                lo_lim = 64'(set_min_fast);
                if (est_filt < 24'(set_slow_lim))
                begin
                    hi_lim = 64'(set_max_slow);
                    lo_lim = 64'(set_min_slow);
                end
                // Ratio test only once a period and a speed exist
                if (take && est_last_per != 32'd0 && est_filt != 24'd0)
                begin
                    scaled = {24'd0, per, 8'd0};
                    if (scaled > hi_lim * 64'(est_last_per) ||
                        scaled < lo_lim * 64'(est_last_per))
                        take = 1'b0;
                end
                if (take)
                begin
                    est_last_per = per;
                    est_ring[est_pos] = per;
                    est_pos = (est_pos == 3'(WINDOW - 1)) ? 3'd0 : est_pos + 3'd1;
                    if (est_fill < 3'(WINDOW))
                        est_fill = est_fill + 3'd1;
                    sum = 64'd0;
                    for (int i = 0; i < int'(est_fill); i++)
                        sum = sum + 64'(est_ring[i]);
                    spd = 64'd0;
                    if (sum != 64'd0)
                        spd = (64'(set_scale) * 64'(est_fill)) / sum;
                    if (spd > 64'(MAX_SPEED24))
                        spd = 64'(MAX_SPEED24);
                    filt_next = (64'(EMA_KEEP) * 64'(est_filt) + 64'(EMA_NEW) * spd)
                                / 64'(EMA_DIV);
                    est_filt = filt_next[23:0];
                end
                est_pending = 1'b1;
                r.acc = take;
            end
            OP_OVERFLOW:
            begin
                est_ovf = est_ovf + 16'd1;
            end
            OP_TICK:
            begin
                if (est_pub >= MIN_DIST_SPEED)
                    est_dist = est_dist + 48'(est_pub);
                if (est_ticks != MAX_U16)
                    est_ticks = est_ticks + 16'd1;
                if (est_ticks > set_timeout)
                begin
                    est_fill = 3'd0;
                    est_pos = 3'd0;
                    est_last_per = 32'd0;
                    est_pub = 16'd0;
                    est_filt = 24'd0;
                    r.tmo = 1'b1;
                end
                if (est_pending)
                begin
                    est_pending = 1'b0;
                    est_pub = (est_filt > 24'(MAX_U16)) ? MAX_U16 : est_filt[15:0];
                end
                r.travel = est_dist;
            end
            default:
            begin
                est_dist = 48'd0;
            end
        endcase
        r.speed = est_pub;
    endtask

    // Offer one input word, hold it until accepted, then queue its result
    task automatic send_word(input logic [1:0] w_op, input logic [15:0] w_cap,
                             input bit typed, input speed_word_t typed_word);
        speed_word_t r;
        if (items_in < TOTAL_WORDS / 3)
        begin
            send_idle_pct = 33;
            recv_idle_pct = 86;
        end
        else if (items_in < 2 * TOTAL_WORDS / 3)
        begin
            send_idle_pct = 86;
            recv_idle_pct = 33;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= w_op;
        capture_value <= w_cap;
        do
            @(posedge clk);
        while (!in_ready);
        predict_speed_word(w_op, w_cap, r);
        if (typed)
            r = typed_word;
        speed_words_due.push_back(r);
        items_in++;
    endtask

    // Stop offering and wait until every queued result word has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (speed_words_due.size() != 0);
    endtask

    // Write every register index from next_cfg and mirror the settings
    task automatic load_settings();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= next_cfg[i];
            @(posedge clk);
            case (3'(i))
                CFG_SPEED_SCALE:    set_scale = next_cfg[i];
                CFG_MAX_RATIO_FAST: set_max_fast = next_cfg[i][15:0];
                CFG_MIN_RATIO_FAST: set_min_fast = next_cfg[i][15:0];
                CFG_MAX_RATIO_SLOW: set_max_slow = next_cfg[i][15:0];
                CFG_MIN_RATIO_SLOW: set_min_slow = next_cfg[i][15:0];
                CFG_SLOW_LIMIT:     set_slow_lim = next_cfg[i][15:0];
                CFG_TIMEOUT:        set_timeout = next_cfg[i][15:0];
                default:            ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Receiver: random ready, plus one long hold-off once traffic is going
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_words++;
            if (period_accepted)
                n_taken++;
            if (timed_out)
                n_timeouts++;
            if (speed_now == MAX_U16)
                n_saturated++;
            if (speed_words_due.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected word speed %0d distance %0d accepted %0b timeout %0b",
                         $time, speed_now, distance, period_accepted, timed_out);
            end
            else
            begin
                want = speed_words_due.pop_front();
                if (speed_now !== want.speed)
                begin
                    fails++;
                    $display("%0t: speed_now expected %0d got %0d",
                             $time, want.speed, speed_now);
                end
                if (distance !== want.travel)
                begin
                    fails++;
                    $display("%0t: distance expected %0d got %0d",
                             $time, want.travel, distance);
                end
                if (period_accepted !== want.acc)
                begin
                    fails++;
                    $display("%0t: period_accepted expected %0b got %0b",
                             $time, want.acc, period_accepted);
                end
                if (timed_out !== want.tmo)
                begin
                    fails++;
                    $display("%0t: timed_out expected %0b got %0b", $time, want.tmo, timed_out);
                end
            end
        end
    end

    // End a hung run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d words outstanding",
                 cycles, speed_words_due.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        speed_word_t typed_word;
        logic [31:0] base;
        logic [31:0] per;
        logic [31:0] target;
        logic [15:0] hi_gap;
        int          run_len;
        int          n_ticks;
        int          n_noise;

        // Drive all inputs known before the first edge
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPEED_SCALE;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        op = OP_EDGE;
        capture_value = 16'd0;
        out_ready = 1'b0;

        // Mirror the reset state
        set_scale = RST_SPEED_SCALE;
        set_max_fast = RST_MAX_RATIO_FAST;
        set_min_fast = RST_MIN_RATIO_FAST;
        set_max_slow = RST_MAX_RATIO_SLOW;
        set_min_slow = RST_MIN_RATIO_SLOW;
        set_slow_lim = RST_SLOW_LIMIT;
        set_timeout = RST_TIMEOUT;
        est_ovf = 16'd0;
        est_last_stamp = 32'd0;
        for (int i = 0; i < WINDOW; i++)
            est_ring[i] = 32'd0;
        est_pos = 3'd0;
        est_fill = 3'd0;
        est_last_per = 32'd0;
        est_filt = 24'd0;
        est_pub = 16'd0;
        est_pending = 1'b0;
        est_dist = 48'd0;
        est_ticks = 16'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: defaults with a short timeout so it trips early
        next_cfg[CFG_SPEED_SCALE] = RST_SPEED_SCALE;
        next_cfg[CFG_MAX_RATIO_FAST] = reg16(RST_MAX_RATIO_FAST);
        next_cfg[CFG_MIN_RATIO_FAST] = reg16(RST_MIN_RATIO_FAST);
        next_cfg[CFG_MAX_RATIO_SLOW] = reg16(RST_MAX_RATIO_SLOW);
        next_cfg[CFG_MIN_RATIO_SLOW] = reg16(RST_MIN_RATIO_SLOW);
        next_cfg[CFG_SLOW_LIMIT] = reg16(RST_SLOW_LIMIT);
        next_cfg[CFG_TIMEOUT] = reg16(16'd3);
        next_cfg[7] = $urandom;
        load_settings();
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            typed_word = '{dir_rows[i].speed, dir_rows[i].travel,
                           dir_rows[i].acc, dir_rows[i].tmo};
            send_word(dir_rows[i].op, dir_rows[i].cap, dir_rows[i].typed, typed_word);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            repeat (4) @(posedge clk);

            // Pick the settings of this phase, extremes included
            case (ph)
                0:
                begin
                    next_cfg[CFG_SPEED_SCALE] = $urandom_range(2000000, 20000000);
                    next_cfg[CFG_MAX_RATIO_FAST] = reg16(RST_MAX_RATIO_FAST);
                    next_cfg[CFG_MIN_RATIO_FAST] = reg16(RST_MIN_RATIO_FAST);
                    next_cfg[CFG_MAX_RATIO_SLOW] = reg16(RST_MAX_RATIO_SLOW);
                    next_cfg[CFG_MIN_RATIO_SLOW] = reg16(RST_MIN_RATIO_SLOW);
                    next_cfg[CFG_SLOW_LIMIT] = reg16(RST_SLOW_LIMIT);
                    next_cfg[CFG_TIMEOUT] = reg16(RST_TIMEOUT);
                end
                1:
                begin
                    next_cfg[CFG_SPEED_SCALE] = 32'hFFFF_FFFF;
                    next_cfg[CFG_MAX_RATIO_FAST] = reg16(16'hFFFF);
                    next_cfg[CFG_MIN_RATIO_FAST] = reg16(16'h0000);
                    next_cfg[CFG_MAX_RATIO_SLOW] = reg16(16'hFFFF);
                    next_cfg[CFG_MIN_RATIO_SLOW] = reg16(16'h0000);
                    next_cfg[CFG_SLOW_LIMIT] = reg16(16'hFFFF);
                    next_cfg[CFG_TIMEOUT] = reg16(16'hFFFF);
                end
                2:
                begin
                    next_cfg[CFG_SPEED_SCALE] = 32'd0;
                    next_cfg[CFG_MAX_RATIO_FAST] = reg16(16'h0000);
                    next_cfg[CFG_MIN_RATIO_FAST] = reg16(16'h0000);
                    next_cfg[CFG_MAX_RATIO_SLOW] = reg16(16'h0000);
                    next_cfg[CFG_MIN_RATIO_SLOW] = reg16(16'h0000);
                    next_cfg[CFG_SLOW_LIMIT] = reg16(16'h0000);
                    next_cfg[CFG_TIMEOUT] = reg16(16'd1);
                end
                3:
                begin
                    next_cfg[CFG_SPEED_SCALE] = $urandom_range(1000000, 50000000);
                    next_cfg[CFG_MAX_RATIO_FAST] = reg16(16'd300);
                    next_cfg[CFG_MIN_RATIO_FAST] = reg16(16'd220);
                    next_cfg[CFG_MAX_RATIO_SLOW] = reg16(16'd400);
                    next_cfg[CFG_MIN_RATIO_SLOW] = reg16(16'd160);
                    next_cfg[CFG_SLOW_LIMIT] = reg16(16'd256);
                    next_cfg[CFG_TIMEOUT] = reg16(16'($urandom_range(2, 6)));
                end
                default:
                begin
                    next_cfg[CFG_SPEED_SCALE] = $urandom;
                    next_cfg[CFG_MAX_RATIO_FAST] = reg16(16'($urandom_range(256, 2048)));
                    next_cfg[CFG_MIN_RATIO_FAST] = reg16(16'($urandom_range(0, 256)));
                    next_cfg[CFG_MAX_RATIO_SLOW] = reg16(16'($urandom_range(256, 4096)));
                    next_cfg[CFG_MIN_RATIO_SLOW] = reg16(16'($urandom_range(0, 256)));
                    next_cfg[CFG_SLOW_LIMIT] = reg16(16'($urandom_range(0, 4096)));
                    next_cfg[CFG_TIMEOUT] = reg16(16'($urandom_range(1, 60)));
                end
            endcase
            next_cfg[7] = $urandom;
            load_settings();

            while (items_in < DIR_ROWS + (ph + 1) * PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    // Well-formed run of edges around one speed class
                    case ($urandom_range(0, 2))
                        0:       base = $urandom_range(2, 400);
                        1:       base = $urandom_range(400, 30000);
                        default: base = $urandom_range(30000, 300000);
                    endcase
                    run_len = $urandom_range(4, 24);
                    for (int e = 0; e < run_len; e++)
                    begin
                        if ($urandom_range(0, 99) < 6)
                            n_ticks = (set_timeout < 16'd60) ? int'(set_timeout) + 2 : 2;
                        else
                            n_ticks = $urandom_range(0, 3);
                        for (int t = 0; t < n_ticks; t++)
                            send_word(OP_TICK, 16'($urandom), 1'b0, '0);
                        if ($urandom_range(0, 99) < 4)
                            send_word(OP_CLEAR, 16'($urandom), 1'b0, '0);

                        // Jitter the period; now and then jump or repeat the edge
                        per = base + $urandom_range(0, base / 5) - base / 10;
                        if ($urandom_range(0, 99) < 8)
                            per = ($urandom_range(0, 1) != 0) ? base * $urandom_range(2, 9)
                                                              : base / $urandom_range(2, 9) + 1;
                        if ($urandom_range(0, 99) < 3)
                            per = 32'd0;
                        target = est_last_stamp + per;
                        hi_gap = target[31:16] - est_ovf;
                        if (hi_gap > 16'd8)
                            target[31:16] = est_ovf;
                        while (est_ovf != target[31:16])
                            send_word(OP_OVERFLOW, 16'($urandom), 1'b0, '0);
                        send_word(OP_EDGE, target[15:0], 1'b0, '0);
                    end
                end
                else
                begin
                    // Noise: random words of any kind
                    n_noise = $urandom_range(1, 6);
                    for (int k = 0; k < n_noise; k++)
                        send_word(2'($urandom), 16'($urandom), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (END_WAIT) @(posedge clk);

        $display("Checked %0d result words: %0d periods taken, %0d timeouts, %0d at full scale",
                 n_words, n_taken, n_timeouts, n_saturated);
        $display("Covered the directed table and %0d settings phases under three idle patterns",
                 PHASES);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
